[rtl/multichannel_offset_ema_filter_unit_defines.svh]
// ----------------------------------------------------------------------------
// multichannel offset ema filter unit: assertion macros
// concurrent assertion helpers shared by the rtl files, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_OFFSET_EMA_FILTER_UNIT_DEFINES_SVH
`define MULTICHANNEL_OFFSET_EMA_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// ante implies cons in the same cycle
`define MOEF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// ante implies cons in the next cycle
`define MOEF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MOEF_ASSERT_IMP(lbl, ante, cons, msg)
`define MOEF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/moef_pkg.sv]
// ----------------------------------------------------------------------------
// moef_pkg
// transaction types and fixed constants of the offset ema filter bank
// ----------------------------------------------------------------------------
`default_nettype none

package moef_pkg;

    localparam int SENSOR_INDEX_W = 4;

    // operation codes
    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_OFFSET  = 1'b1;

    // configuration register indexes
    localparam logic REG_EMA_GAIN     = 1'b0;
    localparam logic REG_PRESENT_MASK = 1'b1;

    // gain limits, q1.15 (0.05 .. 1.0)
    localparam logic [15:0] GAIN_MIN   = 16'd1638;
    localparam logic [15:0] GAIN_MAX   = 16'd32768;
    localparam logic [15:0] GAIN_RESET = 16'd32768;

    typedef struct packed {
        logic                       operation;
        logic [SENSOR_INDEX_W-1:0]  sensor_index;
        logic [15:0]                raw_mm;
        logic                       timed_out;
        logic signed [15:0]         offset_value;
    } moef_in_t;

    typedef struct packed {
        logic [15:0] filtered_mm;
        logic [15:0] calibrated_mm;
        logic        reading_valid;
    } moef_out_t;

    // channel store access controls
    typedef struct packed {
        logic rd_en;
        logic ofs_we;
        logic ema_we;
    } moef_store_ctl_t;

endpackage

`default_nettype wire

[rtl/moef_chan_store.sv]
// ----------------------------------------------------------------------------
// moef_chan_store
// per-channel offset and ema memories with started and offset-written flags
// ----------------------------------------------------------------------------
`default_nettype none
`include "multichannel_offset_ema_filter_unit_defines.svh"

module moef_chan_store
    import moef_pkg::*;
#(
    parameter int CHANNELS = 16,
    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire moef_store_ctl_t ctl,
    input  wire logic [AW-1:0]   addr,
    input  wire logic [15:0]     ofs_wdata,
    input  wire logic [30:0]     ema_wdata,
    output      logic [15:0]     ofs_rdata,
    output      logic [30:0]     ema_rdata,
    output      logic            started
);

    logic [15:0]         ofs_mem [CHANNELS];
    logic [30:0]         ema_mem [CHANNELS];
    logic [CHANNELS-1:0] ofs_written_reg;
    logic [CHANNELS-1:0] started_reg;
    logic [15:0]         ofs_rd_reg;
    logic [30:0]         ema_rd_reg;
    logic                ofs_ok_reg;
    logic                started_rd_reg;

    // memories, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.ofs_we)
        begin
            ofs_mem[addr] <= ofs_wdata;
        end
        if (ctl.ema_we)
        begin
            ema_mem[addr] <= ema_wdata;
        end
        if (ctl.rd_en)
        begin
            ofs_rd_reg <= ofs_mem[addr];
            ema_rd_reg <= ema_mem[addr];
        end
    end

    // flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofs_written_reg <= '0;
            started_reg     <= '0;
            ofs_ok_reg      <= 1'b0;
            started_rd_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.ofs_we)
            begin
                ofs_written_reg[addr] <= 1'b1;
            end
            if (ctl.ema_we)
            begin
                started_reg[addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                ofs_ok_reg     <= ofs_written_reg[addr];
                started_rd_reg <= started_reg[addr];
            end
        end
    end

    // an offset never written reads as zero
    assign ofs_rdata = ofs_ok_reg ? ofs_rd_reg : 16'd0;
    assign ema_rdata = ema_rd_reg;
    assign started   = started_rd_reg;

    `MOEF_ASSERT_IMP(a_no_rd_during_ema_wr, ctl.ema_we, !ctl.rd_en,
        "ema write collides with a read")
    `MOEF_ASSERT_NEXT(a_started_after_wr, ctl.ema_we, started_reg[$past(addr)],
        "started flag not set after ema write")

endmodule

`default_nettype wire

[rtl/multichannel_offset_ema_filter_unit.sv]
// ----------------------------------------------------------------------------
// multichannel_offset_ema_filter_unit
// bank of per-channel offset-corrected exponential moving average filters
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid, in_stall, in_data): one transaction is either an
//   offset write for one channel or a measurement. an offset write is stored
//   at acceptance, keeps the block idle and produces no output transaction.
//   a measurement produces exactly one output transaction (out_valid,
//   out_stall, out_data). it is taken in, walks through the channel memories
//   and the shared multiplier step by step (cal, diff, mul, step, acc, out),
//   and its result is registered on leaving out; the next transaction is
//   taken once the sequencer is back in idle, so a measurement occupies the
//   block until then, for a walk set by the read-modify-write of the channel
//   entry through the synchronous memory and the multiply.
//   a stalled output keeps its result; the block finishes the next
//   measurement and holds it until the output register frees up.
//   configuration (cfg_we, cfg_index, cfg_data) is to be written while idle by the user; the block does not enforce it:
//   index 0 is the gain in q1.15 (clamped to 0.05 .. 1.0), index 1 the
//   sensor present mask.
//   reset sets the gain to 1.0, clears the mask, and marks every channel as
//   unstarted with a zero offset; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multichannel_offset_ema_filter_unit_defines.svh"

module multichannel_offset_ema_filter_unit
    import moef_pkg::*;
#(
    parameter int CHANNELS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire moef_in_t    in_data,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      moef_out_t   out_data,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IW = (AW > SENSOR_INDEX_W) ? AW : SENSOR_INDEX_W;
    localparam logic [7:0] CHAN_LIMIT = 8'(CHANNELS);

    // sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CAL  = 3'd1;
    localparam logic [2:0] ST_DIFF = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_STEP = 3'd4;
    localparam logic [2:0] ST_ACC  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]          state_reg, state_next;
    moef_in_t            item_reg;
    logic [15:0]         gain_reg;
    logic [15:0]         mask_reg;
    logic                ok_reg;
    logic [15:0]         cal_reg;
    logic signed [31:0]  diff_reg;
    logic signed [48:0]  prod_reg;
    logic signed [33:0]  step_reg;
    logic [30:0]         ema_new_reg;
    logic                out_valid_reg;
    moef_out_t           out_data_reg;

    logic                in_accept;
    logic                out_load;
    logic                in_range;
    logic [IW-1:0]       in_idx_ext;
    logic [IW-1:0]       item_idx_ext;
    logic [AW-1:0]       store_addr;
    moef_store_ctl_t     store_ctl;
    logic [15:0]         ofs_rdata;
    logic [30:0]         ema_rdata;
    logic                started;
    logic signed [17:0]  cal_full;
    logic [15:0]         cal_next;
    logic signed [48:0]  prod_rnd;
    logic signed [34:0]  ema_sum;
    logic [30:0]         ema_new;
    logic [31:0]         fil_sum;
    logic [16:0]         fil_full;
    logic [15:0]         gain_clamped;

    // handshakes
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    // channel address: incoming index while idle, held index otherwise
    assign in_idx_ext   = IW'(in_data.sensor_index);
    assign item_idx_ext = IW'(item_reg.sensor_index);
    assign store_addr   = (state_reg == ST_IDLE) ? in_idx_ext[AW-1:0]
                                                 : item_idx_ext[AW-1:0];
    assign in_range     = ({4'd0, in_data.sensor_index} < CHAN_LIMIT);

    // offset writes go straight in; a measurement reads its entry at accept
    // and writes the ema back at most once, so accesses never overlap
    always_comb
    begin
        store_ctl.rd_en  = in_accept && (in_data.operation == OP_MEASURE);
        store_ctl.ofs_we = in_accept && (in_data.operation == OP_OFFSET) && in_range;
        store_ctl.ema_we = (state_reg == ST_ACC) && ok_reg;
    end

    moef_chan_store #(
        .CHANNELS (CHANNELS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (store_ctl),
        .addr      (store_addr),
        .ofs_wdata (in_data.offset_value),
        .ema_wdata (ema_new),
        .ofs_rdata (ofs_rdata),
        .ema_rdata (ema_rdata),
        .started   (started)
    );

    // calibrated reading: raw minus signed offset, clamped to 0..65535
    always_comb
    begin
        cal_full = $signed({2'b00, item_reg.raw_mm}) - 18'($signed(ofs_rdata));
        if (cal_full < 0)
        begin
            cal_next = 16'd0;
        end
        else if (cal_full > 18'sd65535)
        begin
            cal_next = 16'hFFFF;
        end
        else
        begin
            cal_next = cal_full[15:0];
        end
    end

    // round half up then floor shift by 15
    assign prod_rnd = prod_reg + 49'sd16384;

    // new ema: first sample loads, later ones add the step and clamp
    always_comb
    begin
        ema_sum = $signed({4'b0000, ema_rdata}) + 35'(step_reg);
        if (!started)
        begin
            ema_new = {cal_reg, 15'd0};
        end
        else if (ema_sum < 0)
        begin
            ema_new = 31'd0;
        end
        else if (ema_sum > 35'sh7FFFFFFF)
        begin
            ema_new = 31'h7FFFFFFF;
        end
        else
        begin
            ema_new = ema_sum[30:0];
        end
    end

    // filtered output, rounded half up and saturated
    assign fil_sum  = {1'b0, ema_new_reg} + 32'd16384;
    assign fil_full = fil_sum[31:15];

    // gain clamp on write
    always_comb
    begin
        if (cfg_data < GAIN_MIN)
        begin
            gain_clamped = GAIN_MIN;
        end
        else if (cfg_data > GAIN_MAX)
        begin
            gain_clamped = GAIN_MAX;
        end
        else
        begin
            gain_clamped = cfg_data;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (in_data.operation == OP_MEASURE))
                begin
                    state_next = ST_CAL;
                end
            end
            ST_CAL:  state_next = ST_DIFF;
            ST_DIFF: state_next = ST_MUL;
            ST_MUL:  state_next = ST_STEP;
            ST_STEP: state_next = ST_ACC;
            ST_ACC:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gain_reg      <= GAIN_RESET;
            mask_reg      <= 16'd0;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && (cfg_index == REG_EMA_GAIN))
            begin
                gain_reg <= gain_clamped;
            end
            if (cfg_we && (cfg_index == REG_PRESENT_MASK))
            begin
                mask_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            // present, not timed out and in range
            if (state_reg == ST_CAL)
            begin
                ok_reg <= ({4'd0, item_reg.sensor_index} < CHAN_LIMIT)
                          && mask_reg[item_reg.sensor_index]
                          && !item_reg.timed_out;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg <= in_data;
        end
        if (state_reg == ST_CAL)
        begin
            cal_reg <= cal_next;
        end
        if (state_reg == ST_DIFF)
        begin
            diff_reg <= $signed({1'b0, cal_reg, 15'd0}) - $signed({1'b0, ema_rdata});
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= diff_reg * $signed({1'b0, gain_reg});
        end
        if (state_reg == ST_STEP)
        begin
            step_reg <= prod_rnd[48:15];
        end
        if (state_reg == ST_ACC)
        begin
            ema_new_reg <= ema_new;
        end
        if (out_load)
        begin
            if (ok_reg)
            begin
                out_data_reg.filtered_mm   <= fil_full[16] ? 16'hFFFF : fil_full[15:0];
                out_data_reg.calibrated_mm <= cal_reg;
                out_data_reg.reading_valid <= 1'b1;
            end
            else
            begin
                out_data_reg.filtered_mm   <= 16'd0;
                out_data_reg.calibrated_mm <= 16'd0;
                out_data_reg.reading_valid <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `MOEF_ASSERT_NEXT(a_meas_starts_walk, in_accept && (in_data.operation == OP_MEASURE),
        state_reg == ST_CAL, "accepted measurement did not start")
    `MOEF_ASSERT_NEXT(a_hold_when_full, (state_reg == ST_OUT) && out_valid_reg && out_stall,
        state_reg == ST_OUT, "result left while output register was full")
    `MOEF_ASSERT_IMP(a_invalid_is_zero, out_valid_reg && !out_data_reg.reading_valid,
        (out_data_reg.filtered_mm == 16'd0) && (out_data_reg.calibrated_mm == 16'd0),
        "invalid reading carries nonzero data")

endmodule

`default_nettype wire
